@@ hw/rtl/mik_pkg.sv @@
// shared constants and types for the mecanum inverse kinematics block
package mik_pkg;

    // sine phase quantization (depth must be a power of two)
    localparam int SINE_TABLE_DEPTH = 1024;
    localparam int PHASE_W          = $clog2(SINE_TABLE_DEPTH);
    localparam int PHASE_SHIFT      = 16 - PHASE_W;
    localparam int QE_W             = PHASE_W + 1;
    localparam int X_W              = PHASE_W + 18;
    localparam int YAW_OFFSET       = 36000;
    localparam int PHASE_HALF       = 36000;
    localparam int PHASE_DIV        = 72000;
    localparam int RECIP_SHIFT      = 32;
    localparam int PHASE_RECIP      = 59652;   // floor(2^32 / 72000)

    // sine polynomial, Q1.14
    localparam int SIN_C1  = 1160;
    localparam int SIN_C2  = 10512;
    localparam int SIN_C3  = 25736;
    localparam int QUARTER = 16384;

    // wheel lanes and divider widths
    localparam int LANES  = 4;
    localparam int MAG_W  = 26;
    localparam int LIM_W  = 23;
    localparam int QUOT_W = 23;
    localparam int DEN_W  = 27;
    localparam int NUM_W  = 51;
    localparam int OUT_W  = 24;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 23;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_RADIUS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_BT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_O_LAYOUT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WORLD      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HALT       = 3'd5;

    // sideband riding along with the divider lanes
    typedef struct packed {
        logic             scaled;
        logic [LANES-1:0] neg;
    } mik_side_t;

endpackage

@@ hw/rtl/mecanum_inverse_kinematics.sv @@
// top level of the mecanum wheel inverse kinematics pipeline
//
//  channel | direction | handshake            | payload
//  s_      | in        | s_tvalid / s_tready  | tdata: vx, vy, spin, yaw (16 b each)
//  m_      | out       | m_tvalid / m_tready  | tdata: wheel one..four (24 b), tuser: was_scaled
//  cfg_    | in        | cfg_valid / cfg_ready| cfg_index (3 b), cfg_data (23 b)
//
//  one beat in and one beat out per cycle sustained while m_tready is held high; the stages are
//  14 arithmetic stages, a 24 stage divider (a load stage, then one quotient bit per stage) and the output register
//  the whole pipeline advances together; a stalled output register holds every stage
//  aresetn clears valid bits and loads the register reset values
//  configuration is always ready; the user must write it only while no beats are in flight (not enforced here)
module mecanum_inverse_kinematics
    import mik_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [63:0]           s_tdata,    // target_vx, target_vy, target_spin, chassis_yaw
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [95:0]           m_tdata,    // wheel_one, wheel_two, wheel_three, wheel_four
    output logic                  m_tuser,    // was_scaled
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int NSTG = 14;

    // ---------------- configuration registers ----------------
    logic [15:0]      inv_radius_reg;
    logic [15:0]      half_bt_reg;
    logic [LIM_W-1:0] limit_reg;
    logic             o_layout_reg;
    logic             world_reg;
    logic             halt_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inv_radius_reg <= 16'd256;
            half_bt_reg    <= 16'd26214;
            limit_reg      <= {LIM_W{1'b1}};
            o_layout_reg   <= 1'b0;
            world_reg      <= 1'b0;
            halt_reg       <= 1'b1;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_INV_RADIUS: inv_radius_reg <= cfg_data[15:0];
                CFG_HALF_BT:    half_bt_reg    <= cfg_data[15:0];
                CFG_LIMIT:      limit_reg      <= cfg_data[LIM_W-1:0];
                CFG_O_LAYOUT:   o_layout_reg   <= cfg_data[0];
                CFG_WORLD:      world_reg      <= cfg_data[0];
                CFG_HALT:       halt_reg       <= cfg_data[0];
                default: ;   // writes past the register list are dropped
            endcase
        end
    end

    // ---------------- flow control ----------------
    logic            adv;
    logic [NSTG-1:0] vld_reg;
    logic            m_tvalid_reg;

    // every stage moves when the output register is free or being drained
    assign adv      = !m_tvalid_reg || m_tready;
    assign s_tready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[NSTG-2:0], s_tvalid};
        end
    end

    // ---------------- stage 1: phase numerator, spin product ----------------
    logic signed [15:0] in_vx, in_vy, in_spin;
    logic        [15:0] in_yaw;
    logic        [16:0] yaw_pos;
    logic [X_W-1:0]     x_next;

    assign in_vx   = s_tdata[15:0];
    assign in_vy   = s_tdata[31:16];
    assign in_spin = s_tdata[47:32];
    assign in_yaw  = s_tdata[63:48];
    // yaw shifted to positive hundredths of a degree
    assign yaw_pos = {in_yaw[15], in_yaw} + 17'(YAW_OFFSET);
    assign x_next  = (X_W'(yaw_pos) << (PHASE_W + 1)) + X_W'(PHASE_HALF);

    logic signed [15:0] vx1_reg, vy1_reg;
    logic [X_W-1:0]     x1_reg;
    logic signed [32:0] kp1_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            vx1_reg <= in_vx;
            vy1_reg <= in_vy;
            x1_reg  <= x_next;
            kp1_reg <= $signed({1'b0, half_bt_reg}) * in_spin;
        end
    end

    // ---------------- stage 2: reciprocal estimate of the phase, spin rounding ----------------
    logic [X_W+15:0]    qprod;
    logic signed [33:0] kp_round;

    assign qprod    = x1_reg * 16'(PHASE_RECIP);
    assign kp_round = {kp1_reg[32], kp1_reg} + 34'sd32768;

    logic signed [15:0] vx2_reg, vy2_reg;
    logic [X_W-1:0]     x2_reg;
    logic [QE_W-1:0]    qe2_reg;
    logic signed [17:0] kw2_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            vx2_reg <= vx1_reg;
            vy2_reg <= vy1_reg;
            x2_reg  <= x1_reg;
            qe2_reg <= qprod[RECIP_SHIFT +: QE_W];
            kw2_reg <= kp_round[33:16];
        end
    end

    // ---------------- stage 3: phase correction and wrap ----------------
    logic [X_W-1:0]     ph_rem;
    logic [QE_W-1:0]    ph_q;
    logic [PHASE_W-1:0] ph_p;

    // the estimate is low by at most one
    always_comb begin
        ph_rem = x2_reg - X_W'(32'(qe2_reg) * 32'(PHASE_DIV));
        ph_q   = qe2_reg + QE_W'(ph_rem >= X_W'(PHASE_DIV));
        if (ph_q >= QE_W'(SINE_TABLE_DEPTH)) begin
            ph_p = PHASE_W'(ph_q - QE_W'(SINE_TABLE_DEPTH));
        end else begin
            ph_p = ph_q[PHASE_W-1:0];
        end
    end

    logic signed [15:0] vx3_reg, vy3_reg;
    logic signed [17:0] kw3_reg;
    logic [15:0]        u3_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            vx3_reg <= vx2_reg;
            vy3_reg <= vy2_reg;
            kw3_reg <= kw2_reg;
            u3_reg  <= 16'(ph_p) << PHASE_SHIFT;
        end
    end

    // ---------------- stages 4..7: sine (index 0) and cosine (index 1) ----------------
    logic [15:0] ang    [2];
    logic [14:0] fold   [2];
    logic [29:0] fsq    [2];
    logic [25:0] c1prod [2];
    logic [28:0] i1prod [2];
    logic [29:0] i2prod [2];

    assign ang[0] = u3_reg;
    assign ang[1] = u3_reg + 16'(QUARTER);   // cosine is a quarter turn ahead

    logic [14:0] f4_reg  [2];
    logic [14:0] t24_reg [2];
    logic        n4_reg  [2];
    logic [14:0] f5_reg  [2];
    logic [14:0] t25_reg [2];
    logic [13:0] i15_reg [2];
    logic        n5_reg  [2];
    logic [14:0] f6_reg  [2];
    logic [14:0] i26_reg [2];
    logic        n6_reg  [2];
    logic signed [16:0] trig7_reg [2];

    always_comb begin
        for (int j = 0; j < 2; j++) begin
            // mirror odd quadrants onto the rising quarter
            fold[j]   = ang[j][14] ? 15'(QUARTER) - {1'b0, ang[j][13:0]}
                                   : {1'b0, ang[j][13:0]};
            fsq[j]    = fold[j] * fold[j];
            c1prod[j] = t24_reg[j] * 11'(SIN_C1);
            i1prod[j] = i15_reg[j] * t25_reg[j];
            i2prod[j] = i26_reg[j] * f6_reg[j];
        end
    end

    logic signed [15:0] vx4_reg, vy4_reg, vx5_reg, vy5_reg, vx6_reg, vy6_reg, vx7_reg, vy7_reg;
    logic signed [17:0] kw4_reg, kw5_reg, kw6_reg, kw7_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int j = 0; j < 2; j++) begin
                f4_reg[j]    <= fold[j];
                t24_reg[j]   <= fsq[j][28:14];
                n4_reg[j]    <= ang[j][15];
                f5_reg[j]    <= f4_reg[j];
                t25_reg[j]   <= t24_reg[j];
                n5_reg[j]    <= n4_reg[j];
                i15_reg[j]   <= 14'(SIN_C2) - 14'(c1prod[j][25:14]);
                f6_reg[j]    <= f5_reg[j];
                n6_reg[j]    <= n5_reg[j];
                i26_reg[j]   <= 15'(SIN_C3) - i1prod[j][28:14];
                trig7_reg[j] <= n6_reg[j] ? -$signed({1'b0, i2prod[j][29:14]})
                                          :  $signed({1'b0, i2prod[j][29:14]});
            end
            vx4_reg <= vx3_reg;  vy4_reg <= vy3_reg;  kw4_reg <= kw3_reg;
            vx5_reg <= vx4_reg;  vy5_reg <= vy4_reg;  kw5_reg <= kw4_reg;
            vx6_reg <= vx5_reg;  vy6_reg <= vy5_reg;  kw6_reg <= kw5_reg;
            vx7_reg <= vx6_reg;  vy7_reg <= vy6_reg;  kw7_reg <= kw6_reg;
        end
    end

    // ---------------- stage 8: rotation products ----------------
    logic signed [32:0] cvx8_reg, svy8_reg, cvy8_reg, svx8_reg;
    logic signed [15:0] vx8_reg, vy8_reg;
    logic signed [17:0] kw8_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            cvx8_reg <= trig7_reg[1] * vx7_reg;
            svy8_reg <= trig7_reg[0] * vy7_reg;
            cvy8_reg <= trig7_reg[1] * vy7_reg;
            svx8_reg <= trig7_reg[0] * vx7_reg;
            vx8_reg  <= vx7_reg;
            vy8_reg  <= vy7_reg;
            kw8_reg  <= kw7_reg;
        end
    end

    // ---------------- stage 9: body frame velocity ----------------
    logic signed [33:0] bx_sum, by_sum;

    assign bx_sum = {cvx8_reg[32], cvx8_reg} + {svy8_reg[32], svy8_reg} + 34'sd8192;
    assign by_sum = {cvy8_reg[32], cvy8_reg} - {svx8_reg[32], svx8_reg} + 34'sd8192;

    logic signed [19:0] bx9_reg, by9_reg;
    logic signed [17:0] kw9_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            bx9_reg <= world_reg ? bx_sum[33:14] : 20'(vx8_reg);
            by9_reg <= world_reg ? by_sum[33:14] : 20'(vy8_reg);
            kw9_reg <= kw8_reg;
        end
    end

    // ---------------- stage 10: wheel mixing ----------------
    logic signed [21:0] mix_b, mix_p, mix_q;

    // O layout flips the sign of the lateral and spin terms
    assign mix_b = 22'(bx9_reg);
    assign mix_p = o_layout_reg ? -22'(by9_reg) : 22'(by9_reg);
    assign mix_q = o_layout_reg ? -22'(kw9_reg) : 22'(kw9_reg);

    logic signed [21:0] lin10_reg [LANES];

    always_ff @(posedge aclk) begin
        if (adv) begin
            lin10_reg[0] <= mix_b - mix_p + mix_q;
            lin10_reg[1] <= mix_b + mix_p - mix_q;
            lin10_reg[2] <= mix_b + mix_p + mix_q;
            lin10_reg[3] <= mix_b - mix_p - mix_q;
        end
    end

    // ---------------- stage 11: scale by inverse radius ----------------
    logic signed [38:0] wp11_reg [LANES];

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int l = 0; l < LANES; l++) begin
                wp11_reg[l] <= $signed({1'b0, inv_radius_reg}) * lin10_reg[l];
            end
        end
    end

    // ---------------- stage 12: round, split sign and magnitude ----------------
    logic signed [39:0] w_round [LANES];
    logic signed [27:0] w_val   [LANES];
    logic        [27:0] w_abs   [LANES];

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            w_round[l] = {wp11_reg[l][38], wp11_reg[l]} + 40'sd128;
            w_val[l]   = w_round[l][35:8];
            w_abs[l]   = w_val[l][27] ? 28'(-w_val[l]) : 28'(w_val[l]);
        end
    end

    logic [MAG_W-1:0] a12_reg [LANES];
    logic [LANES-1:0] n12_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int l = 0; l < LANES; l++) begin
                a12_reg[l] <= w_abs[l][MAG_W-1:0];
                n12_reg[l] <= w_val[l][27];
            end
        end
    end

    // ---------------- stage 13: largest magnitude ----------------
    logic [MAG_W-1:0] max01, max23;

    assign max01 = (a12_reg[0] > a12_reg[1]) ? a12_reg[0] : a12_reg[1];
    assign max23 = (a12_reg[2] > a12_reg[3]) ? a12_reg[2] : a12_reg[3];

    logic [MAG_W-1:0] a13_reg [LANES];
    logic [LANES-1:0] n13_reg;
    logic [MAG_W-1:0] m13_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            a13_reg <= a12_reg;
            n13_reg <= n12_reg;
            m13_reg <= (max01 > max23) ? max01 : max23;
        end
    end

    // ---------------- stage 14: limit products ----------------
    logic [MAG_W+LIM_W-1:0] lp14_reg [LANES];
    logic [MAG_W-1:0]       a14_reg  [LANES];
    logic [LANES-1:0]       n14_reg;
    logic [MAG_W-1:0]       m14_reg;
    logic                   sc14_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int l = 0; l < LANES; l++) begin
                lp14_reg[l] <= a13_reg[l] * limit_reg;
            end
            a14_reg  <= a13_reg;
            n14_reg  <= n13_reg;
            m14_reg  <= m13_reg;
            sc14_reg <= m13_reg > MAG_W'(limit_reg);
        end
    end

    // ---------------- divider: (2*a*limit + m) / (2*m), or a / 1 when unscaled ----------------
    logic [LANES-1:0][NUM_W-1:0]  div_numer;
    logic [DEN_W-1:0]             div_den;
    mik_side_t                    div_side_in, div_side_out;
    logic                         div_valid;
    logic [LANES-1:0][QUOT_W-1:0] div_quot;

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            div_numer[l] = sc14_reg ? {lp14_reg[l], 1'b0} + NUM_W'(m14_reg)
                                    : NUM_W'(a14_reg[l]);
        end
        div_den            = sc14_reg ? {m14_reg, 1'b0} : DEN_W'(1);
        div_side_in.scaled = sc14_reg;
        div_side_in.neg    = n14_reg;
    end

    mik_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (vld_reg[NSTG-1]),
        .in_side   (div_side_in),
        .in_numer  (div_numer),
        .in_den    (div_den),
        .out_valid (div_valid),
        .out_side  (div_side_out),
        .out_quot  (div_quot)
    );

    // ---------------- output register ----------------
    logic [95:0] m_tdata_reg;
    logic        m_tuser_reg;
    logic [95:0] m_tdata_next;

    // quotients never exceed the limit, so no clamp is needed here
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            if (halt_reg) begin
                m_tdata_next[l*OUT_W +: OUT_W] = '0;
            end else if (div_side_out.neg[l]) begin
                m_tdata_next[l*OUT_W +: OUT_W] = -{1'b0, div_quot[l]};
            end else begin
                m_tdata_next[l*OUT_W +: OUT_W] = {1'b0, div_quot[l]};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            m_tvalid_reg <= div_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= div_side_out.scaled && !halt_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // every delivered wheel lies within the configured limit
    logic within_limit;

    always_comb begin
        within_limit = 1'b1;
        for (int l = 0; l < LANES; l++) begin
            if ($signed(m_tdata_reg[l*OUT_W +: OUT_W]) > $signed({1'b0, limit_reg}) ||
                $signed(m_tdata_reg[l*OUT_W +: OUT_W]) < -$signed({1'b0, limit_reg})) begin
                within_limit = 1'b0;
            end
        end
    end

    a_out_cleared: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");

    a_halt_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && halt_reg |-> m_tdata == '0 && !m_tuser)
        else $error("nonzero wheel while halted");

    a_within_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !halt_reg |-> within_limit)
        else $error("wheel speed beyond limit");

endmodule

@@ hw/rtl/mik_div.sv @@
// pipelined restoring divider, four lanes sharing one divisor, one bit per stage
module mik_div
    import mik_pkg::*;
(
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          in_valid,
    input  mik_side_t                     in_side,
    input  logic [LANES-1:0][NUM_W-1:0]   in_numer,
    input  logic [DEN_W-1:0]              in_den,
    output logic                          out_valid,
    output mik_side_t                     out_side,
    output logic [LANES-1:0][QUOT_W-1:0]  out_quot
);

    logic              valid_reg [QUOT_W+1];
    mik_side_t         side_reg  [QUOT_W+1];
    logic [DEN_W-1:0]  den_reg   [QUOT_W+1];
    logic [DEN_W-1:0]  rem_reg   [QUOT_W+1][LANES];
    logic [QUOT_W-1:0] lq_reg    [QUOT_W+1][LANES];   // dividend bits out, quotient bits in

    // load stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg[0] <= 1'b0;
        end else if (en) begin
            valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0] <= in_side;
            den_reg[0]  <= in_den;
            for (int l = 0; l < LANES; l++) begin
                rem_reg[0][l] <= in_numer[l][QUOT_W+DEN_W-1:QUOT_W];
                lq_reg[0][l]  <= in_numer[l][QUOT_W-1:0];
            end
        end
    end

    for (genvar k = 0; k < QUOT_W; k++) begin : g_step
        logic [DEN_W:0]   part [LANES];
        logic [DEN_W+1:0] diff [LANES];

        for (genvar l = 0; l < LANES; l++) begin : g_lane
            assign part[l] = {rem_reg[k][l], lq_reg[k][l][QUOT_W-1]};
            assign diff[l] = {1'b0, part[l]} - {2'b00, den_reg[k]};
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k+1] <= 1'b0;
            end else if (en) begin
                valid_reg[k+1] <= valid_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                side_reg[k+1] <= side_reg[k];
                den_reg[k+1]  <= den_reg[k];
                for (int l = 0; l < LANES; l++) begin
                    rem_reg[k+1][l] <= diff[l][DEN_W+1] ? part[l][DEN_W-1:0]
                                                        : diff[l][DEN_W-1:0];
                    lq_reg[k+1][l]  <= {lq_reg[k][l][QUOT_W-2:0], ~diff[l][DEN_W+1]};
                end
            end
        end
    end

    assign out_valid = valid_reg[QUOT_W];
    assign out_side  = side_reg[QUOT_W];
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            out_quot[l] = lq_reg[QUOT_W][l];
        end
    end

    // a finished division leaves a remainder below the divisor in every lane
    a_rem_below_den: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg[QUOT_W] |->
            (rem_reg[QUOT_W][0] < den_reg[QUOT_W]) && (rem_reg[QUOT_W][1] < den_reg[QUOT_W]) &&
            (rem_reg[QUOT_W][2] < den_reg[QUOT_W]) && (rem_reg[QUOT_W][3] < den_reg[QUOT_W]))
        else $error("divider remainder not below divisor");

    // unscaled items pass their magnitude through a unit divisor
    a_unit_den: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg[0] && !side_reg[0].scaled |-> den_reg[0] == DEN_W'(1))
        else $error("unscaled item without unit divisor");

endmodule

@@ test/tb_top.sv @@
// testbench for the mecanum wheel inverse kinematics pipeline
module tb_top;
    import mik_pkg::*;

    // expected wheel speeds and scale flag for one command
    typedef struct packed {
        logic [23:0] w1, w2, w3, w4;
        logic        scaled;
    } wheel_set_t;

    // scoreboard: predicts wheel speeds from a command, checks output beats
    class wheel_scoreboard;
        wheel_set_t pending[$];
        int         errors;
        int         checked;
        logic [15:0] inv_r, half_bt;
        logic [22:0] limit;
        logic        o_layout, world, halt;

        function new();
            errors  = 0;
            checked = 0;
            inv_r   = 16'd256;
            half_bt = 16'd26214;
            limit   = 23'h7FFFFF;
            o_layout = 1'b0;
            world    = 1'b0;
            halt     = 1'b1;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [22:0] val);
            case (idx)
                CFG_INV_RADIUS: inv_r   = val[15:0];
                CFG_HALF_BT:    half_bt = val[15:0];
                CFG_LIMIT:      limit   = val;
                CFG_O_LAYOUT:   o_layout = val[0];
                CFG_WORLD:      world    = val[0];
                CFG_HALT:       halt     = val[0];
                default: ;
            endcase
        endfunction

        // floor(x / 2^sh + 1/2)
        function longint rnd_shift(longint x, int sh);
            return (x + (longint'(1) <<< (sh - 1))) >>> sh;
        endfunction

        function longint sine_q14(int u);
            int q;
            longint f, t2, i1, i2, mag;
            q = (u >> 14) & 3;
            f = u & 16383;
            if (q[0]) f = QUARTER - f;
            t2 = (f * f) >> 14;
            i1 = SIN_C2 - ((SIN_C1 * t2) >> 14);
            i2 = SIN_C3 - ((i1 * t2) >> 14);
            mag = (i2 * f) >> 14;
            return (q >= 2) ? -mag : mag;
        endfunction

        function void note_command(logic [63:0] d);
            longint vx, vy, spin, yaw, bx, by, kw, p, q, y, ph, sn, cs, m, a, r;
            longint lin[4], w[4];
            int u;
            wheel_set_t e;
            vx = longint'($signed(d[15:0]));
            vy = longint'($signed(d[31:16]));
            spin = longint'($signed(d[47:32]));
            yaw = longint'($signed(d[63:48]));
            e = '0;
            if (!halt) begin
                bx = vx;
                by = vy;
                if (world) begin
                    y  = yaw + YAW_OFFSET;
                    ph = ((y * 2 * SINE_TABLE_DEPTH + PHASE_HALF) / PHASE_DIV)
                         % SINE_TABLE_DEPTH;
                    u  = int'((ph * 65536) / SINE_TABLE_DEPTH);
                    sn = sine_q14(u);
                    cs = sine_q14((u + QUARTER) & 16'hFFFF);
                    bx = rnd_shift(cs * vx + sn * vy, 14);
                    by = rnd_shift(cs * vy - sn * vx, 14);
                end
                kw = rnd_shift(longint'(half_bt) * spin, 16);
                p  = o_layout ? -by : by;
                q  = o_layout ? -kw : kw;
                lin[0] = bx - p + q;
                lin[1] = bx + p - q;
                lin[2] = bx + p + q;
                lin[3] = bx - p - q;
                m = 0;
                for (int i = 0; i < 4; i++) begin
                    w[i] = rnd_shift(longint'(inv_r) * lin[i], 8);
                    a = (w[i] < 0) ? -w[i] : w[i];
                    if (a > m) m = a;
                end
                if (m > longint'(limit)) begin
                    e.scaled = 1'b1;
                    for (int i = 0; i < 4; i++) begin
                        a = (w[i] < 0) ? -w[i] : w[i];
                        r = (2 * a * longint'(limit) + m) / (2 * m);
                        w[i] = (w[i] < 0) ? -r : r;
                    end
                end
                // clamp guards the output width only
                for (int i = 0; i < 4; i++) begin
                    if (w[i] > 8388607) w[i] = 8388607;
                    if (w[i] < -8388608) w[i] = -8388608;
                end
                e.w1 = w[0][23:0];
                e.w2 = w[1][23:0];
                e.w3 = w[2][23:0];
                e.w4 = w[3][23:0];
            end
            pending.push_back(e);
        endfunction

        function void cmp(string name, logic [23:0] exp_v, logic [23:0] act_v);
            if (exp_v !== act_v) begin
                $error("%s mismatch: expected %0d actual %0d", name,
                       $signed(exp_v), $signed(act_v));
                errors++;
            end
        endfunction

        function void check_beat(logic [95:0] d, logic user);
            wheel_set_t e;
            if (pending.size() == 0) begin
                $error("unexpected output beat %h", d);
                errors++;
                return;
            end
            e = pending.pop_front();
            checked++;
            cmp("wheel_one", e.w1, d[23:0]);
            cmp("wheel_two", e.w2, d[47:24]);
            cmp("wheel_three", e.w3, d[71:48]);
            cmp("wheel_four", e.w4, d[95:72]);
            cmp("was_scaled", {23'd0, e.scaled}, {23'd0, user});
        endfunction
    endclass

    localparam int LATENCY   = 39;
    localparam int MAX_CYCLES = 400000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [95:0] m_tdata;
    logic        m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    wheel_scoreboard sb;
    int  cycles = 0;
    bit  rx_idle_off = 1'b0;   // stretches where the receiver never stalls
    int  n_cmds = 0;

    mecanum_inverse_kinematics uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYCLES) begin
            $display("mecanum_inverse_kinematics test failed");
            $finish;
        end
    end

    // receiver: checks on handshake, then a random stall drawn per beat unless rx_idle_off is set
    initial begin
        int gap;
        sb = new();
        forever begin
            @(posedge aclk);
            if (!aresetn) begin
                m_tready <= 1'b0;
            end else if (m_tvalid && m_tready) begin
                sb.check_beat(m_tdata, m_tuser);
                gap = rx_idle_off ? 0 : $urandom_range(0, 9);
                if (gap > 0) begin
                    m_tready <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // one register write while idle; cfg_valid is dropped again before the task returns
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [22:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.set_reg(idx, val);
        @(posedge aclk);
    endtask

    // send one command; gap drawn per beat unless burst
    task automatic send_cmd(logic [63:0] d, bit burst);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        do @(posedge aclk); while (!s_tready);
        sb.note_command(d);
        n_cmds++;
    endtask

    task automatic end_burst();
        s_tvalid <= 1'b0;
        @(posedge aclk);
    endtask

    // wait for all expected beats plus pipeline drain
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (LATENCY + 5) @(posedge aclk);
    endtask

    function automatic logic [63:0] pack_cmd(int vx, int vy, int sp, int yw);
        return {yw[15:0], sp[15:0], vy[15:0], vx[15:0]};
    endfunction

    function automatic logic [63:0] rand_cmd();
        logic [15:0] yw;
        // mostly in range yaw, sometimes any 16 bit pattern
        yw = ($urandom_range(0, 7) == 0) ? 16'($urandom)
                                         : 16'($urandom_range(0, 36000) - 18000);
        case ($urandom_range(0, 3))
            0: return {yw, 48'($urandom) ^ {16'($urandom), 32'($urandom)}};
            1: return {yw, 16'($signed(16'($urandom_range(0, 1023))) - 512),
                       16'($urandom_range(0, 1023) - 512),
                       16'($urandom_range(0, 1023) - 512)};
            default: return {yw, 16'($urandom), 16'($urandom), 16'($urandom)};
        endcase
    endfunction

    initial begin
        int vals[6];
        logic [63:0] corner[$];
        vals = '{-32768, 32767, 0, -1, 1, 256};
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // halt is on after reset: outputs must be zero
        send_cmd(pack_cmd(32767, -32768, 1000, 4500), 0);
        send_cmd(pack_cmd(-32768, 32767, -32768, -18000), 0);
        drain();

        // directed corners, body frame
        write_reg(CFG_HALT, 23'd0);
        corner.push_back(pack_cmd(0, 0, 0, 0));
        corner.push_back(pack_cmd(32767, 32767, 32767, 18000));
        corner.push_back(pack_cmd(-32768, -32768, -32768, -18000));
        corner.push_back(pack_cmd(256, 0, 0, 0));
        corner.push_back(pack_cmd(0, 256, 0, 0));
        corner.push_back(pack_cmd(0, 0, 256, 0));
        corner.push_back(pack_cmd(-1, 1, -1, 32767));
        foreach (corner[i]) send_cmd(corner[i], 0);
        drain();

        // world frame with yaw extremes and out of range yaw, O layout
        write_reg(CFG_WORLD, 23'd1);
        write_reg(CFG_O_LAYOUT, 23'd1);
        foreach (vals[i]) send_cmd(pack_cmd(vals[i], -vals[i], vals[i], 0), 0);
        send_cmd(pack_cmd(1000, 500, 100, 9000), 0);
        send_cmd(pack_cmd(1000, 500, 100, -9000), 0);
        send_cmd(pack_cmd(1000, 500, 100, 18000), 0);
        send_cmd(pack_cmd(1000, 500, 100, -32768), 0);
        send_cmd(pack_cmd(1000, 500, 100, 32767), 0);
        drain();

        // zero radius, then zero limit
        write_reg(CFG_INV_RADIUS, 23'd0);
        send_cmd(pack_cmd(32767, 100, -200, 0), 0);
        drain();
        write_reg(CFG_INV_RADIUS, 23'd65535);
        write_reg(CFG_LIMIT, 23'd0);
        send_cmd(pack_cmd(0, 0, 0, 0), 0);
        send_cmd(pack_cmd(1, 0, 0, 0), 0);
        send_cmd(pack_cmd(-32768, 32767, -32768, 100), 0);
        drain();

        // random phases across register settings
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: begin
                    write_reg(CFG_INV_RADIUS, 23'd256);
                    write_reg(CFG_HALF_BT, 23'd0);
                    write_reg(CFG_LIMIT, 23'h7FFFFF);
                    write_reg(CFG_O_LAYOUT, 23'd0);
                    write_reg(CFG_WORLD, 23'd0);
                end
                1: begin
                    write_reg(CFG_HALF_BT, 23'd65535);
                    write_reg(CFG_INV_RADIUS, 23'd65535);
                end
                2: begin
                    write_reg(CFG_WORLD, 23'd1);
                    write_reg(CFG_LIMIT, 23'd1);
                end
                3: write_reg(CFG_HALT, 23'd1);
                default: begin
                    write_reg(CFG_HALT, 23'd0);
                    write_reg(CFG_INV_RADIUS, 23'($urandom_range(1, 65535)));
                    write_reg(CFG_HALF_BT, 23'($urandom));
                    write_reg(CFG_LIMIT, 23'($urandom_range(0, 1) ? $urandom
                                             : $urandom_range(0, 20000)));
                    write_reg(CFG_O_LAYOUT, 23'($urandom_range(0, 1)));
                    write_reg(CFG_WORLD, 23'($urandom_range(0, 1)));
                end
            endcase
            rx_idle_off = (ph == 5);
            for (int k = 0; k < 60; k++) begin
                // bursts with no sender gaps, at full rate while the receiver does not stall the pipeline
                send_cmd(rand_cmd(), (ph == 4 || ph == 5) || (k % 20) < 5);
            end
            end_burst();
            drain();
        end
        rx_idle_off = 1'b0;

        $display("sent %0d commands, %0d results checked across halt, body and world frame,",
                 n_cmds, sb.checked);
        $display("both layouts, zero and full radius, and zero to full speed limits");
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("mecanum_inverse_kinematics test passed");
        end else begin
            $display("mecanum_inverse_kinematics test failed");
        end
        $finish;
    end
endmodule
